FILE: sv/imsm_pkg.sv
package imsm_pkg;

    // Field widths
    localparam int COUNT_WIDTH  = 63;
    localparam int TAG_WIDTH    = 8;
    localparam int MARGIN_WIDTH = 32;

    // Signed offset: a margin combined with the shift, with room for the sign
    localparam int OFF_WIDTH = MARGIN_WIDTH + 2;

    // Signed sum of a count and an offset, wide enough never to wrap
    localparam int SUM_WIDTH = ((COUNT_WIDTH > OFF_WIDTH) ? COUNT_WIDTH : OFF_WIDTH) + 2;

    // Configuration port
    localparam int CFG_DATA_WIDTH  = (COUNT_WIDTH > MARGIN_WIDTH) ? COUNT_WIDTH : MARGIN_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;

    // Result queue
    localparam int RES_DEPTH     = 4;
    localparam int RES_PTR_WIDTH = $clog2(RES_DEPTH);
    localparam int RES_CNT_WIDTH = $clog2(RES_DEPTH + 1);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_BACK_MARGIN  = 3'd0,
        CFG_FWD_MARGIN   = 3'd1,
        CFG_TIME_SHIFT   = 3'd2,
        CFG_MERGE_ENABLE = 3'd3,
        CFG_MAX_COUNT    = 3'd4
    } t_cfg_index;

    typedef logic [COUNT_WIDTH-1:0]      t_count;
    typedef logic [TAG_WIDTH-1:0]        t_tag;
    typedef logic signed [OFF_WIDTH-1:0] t_offset;

    // Settings as seen by the datapath
    typedef struct packed {
        t_offset start_off;
        t_offset end_off;
        t_count  max_count;
        logic    merge_en;
        logic    pass;
    } t_cfg;

    // Interval after moving and saturation
    typedef struct packed {
        t_count start_cnt;
        t_count end_cnt;
        t_tag   tag;
        logic   fin;
        logic   pass;
    } t_move;

    // One result beat
    typedef struct packed {
        t_count start_cnt;
        t_count end_cnt;
        t_tag   tag;
        logic   last;
    } t_result;

endpackage

FILE: sv/imsm_cfg.sv
module imsm_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [imsm_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [imsm_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output imsm_pkg::t_cfg                       o_cfg
);
    import imsm_pkg::*;

    logic [MARGIN_WIDTH-1:0]        r_back, n_back;
    logic [MARGIN_WIDTH-1:0]        r_fwd, n_fwd;
    logic signed [MARGIN_WIDTH-1:0] r_shift, n_shift;
    logic                           r_merge_en, n_merge_en;
    t_count                         r_max_count, n_max_count;
    t_offset                        r_start_off, n_start_off;
    t_offset                        r_end_off, n_end_off;

    // Decode the register write
    always_comb begin
        n_back      = r_back;
        n_fwd       = r_fwd;
        n_shift     = r_shift;
        n_merge_en  = r_merge_en;
        n_max_count = r_max_count;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BACK_MARGIN:  n_back      = i_cfg_data[MARGIN_WIDTH-1:0];
                CFG_FWD_MARGIN:   n_fwd       = i_cfg_data[MARGIN_WIDTH-1:0];
                CFG_TIME_SHIFT:   n_shift     = $signed(i_cfg_data[MARGIN_WIDTH-1:0]);
                CFG_MERGE_ENABLE: n_merge_en  = i_cfg_data[0];
                CFG_MAX_COUNT:    n_max_count = i_cfg_data[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Fold margins and shift into one signed offset per bound
    always_comb begin
        n_start_off = {{(OFF_WIDTH-MARGIN_WIDTH){n_shift[MARGIN_WIDTH-1]}}, n_shift}
                    - $signed({{(OFF_WIDTH-MARGIN_WIDTH){1'b0}}, n_back});
        n_end_off   = {{(OFF_WIDTH-MARGIN_WIDTH){n_shift[MARGIN_WIDTH-1]}}, n_shift}
                    + $signed({{(OFF_WIDTH-MARGIN_WIDTH){1'b0}}, n_fwd});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back      <= '0;
            r_fwd       <= '0;
            r_shift     <= '0;
            r_merge_en  <= 1'b0;
            r_max_count <= '1;
            r_start_off <= '0;
            r_end_off   <= '0;
        end else begin
            r_back      <= n_back;
            r_fwd       <= n_fwd;
            r_shift     <= n_shift;
            r_merge_en  <= n_merge_en;
            r_max_count <= n_max_count;
            r_start_off <= n_start_off;
            r_end_off   <= n_end_off;
        end
    end

    always_comb begin
        o_cfg.start_off = r_start_off;
        o_cfg.end_off   = r_end_off;
        o_cfg.max_count = r_max_count;
        o_cfg.merge_en  = r_merge_en;
        o_cfg.pass      = (r_back == '0) && (r_fwd == '0) && (r_shift == '0);
    end

endmodule

FILE: sv/imsm_shift.sv
module imsm_shift (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  imsm_pkg::t_count       i_start_count,
    input  imsm_pkg::t_count       i_end_count,
    input  imsm_pkg::t_tag         i_tag,
    input  logic                   i_is_final,
    output logic                   o_in_stall,
    input  imsm_pkg::t_cfg         i_cfg,
    input  logic                   i_mv_take,
    output logic                   o_mv_valid,
    output imsm_pkg::t_move        o_mv
);
    import imsm_pkg::*;

    logic   r_in_valid;
    t_count r_in_start;
    t_count r_in_end;
    t_tag   r_in_tag;
    logic   r_in_fin;

    logic   r_mv_valid;
    t_move  r_mv;
    t_move  n_mv;

    logic   in_accept;
    logic   mv_load;

    // Add a signed offset, clamp below at zero and above at the maximum count
    function automatic t_count move_sat(t_count x, t_offset off, t_count maxc);
        logic signed [SUM_WIDTH-1:0] sum;
        logic signed [SUM_WIDTH-1:0] lim;
        sum = $signed({{(SUM_WIDTH-COUNT_WIDTH){1'b0}}, x})
            + {{(SUM_WIDTH-OFF_WIDTH){off[OFF_WIDTH-1]}}, off};
        lim = $signed({{(SUM_WIDTH-COUNT_WIDTH){1'b0}}, maxc});
        if (sum[SUM_WIDTH-1]) begin
            return '0;
        end else if (sum > lim) begin
            return maxc;
        end else begin
            return sum[COUNT_WIDTH-1:0];
        end
    endfunction

    // Stage handshakes
    assign mv_load    = r_in_valid && (!r_mv_valid || i_mv_take);
    assign o_in_stall = r_in_valid && !mv_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Move both bounds, or pass them through untouched when nothing moves
    always_comb begin
        n_mv.tag  = r_in_tag;
        n_mv.fin  = r_in_fin;
        n_mv.pass = i_cfg.pass;
        if (i_cfg.pass) begin
            n_mv.start_cnt = r_in_start;
            n_mv.end_cnt   = r_in_end;
        end else begin
            n_mv.start_cnt = move_sat(r_in_start, i_cfg.start_off, i_cfg.max_count);
            n_mv.end_cnt   = move_sat(r_in_end, i_cfg.end_off, i_cfg.max_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mv_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !mv_load);
            r_mv_valid <= mv_load || (r_mv_valid && !i_mv_take);
        end
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_start <= i_start_count;
            r_in_end   <= i_end_count;
            r_in_tag   <= i_tag;
            r_in_fin   <= i_is_final;
        end
    end

    // Hold the moved interval until the merge stage takes it
    always_ff @(posedge i_clk) begin
        if (mv_load) begin
            r_mv <= n_mv;
        end
    end

    assign o_mv_valid = r_mv_valid;
    assign o_mv       = r_mv;

    a_start_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mv_valid && !r_mv.pass) |-> (r_mv.start_cnt <= i_cfg.max_count))
        else $error("moved start above maximum count");

    a_end_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mv_valid && !r_mv.pass) |-> (r_mv.end_cnt <= i_cfg.max_count))
        else $error("moved end above maximum count");

endmodule

FILE: sv/imsm_merge.sv
module imsm_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  imsm_pkg::t_cfg    i_cfg,
    input  logic              i_mv_valid,
    input  imsm_pkg::t_move   i_mv,
    output logic              o_mv_take,
    output logic              o_out_valid,
    output imsm_pkg::t_result o_res,
    input  logic              i_out_stall
);
    import imsm_pkg::*;

    logic                     r_held_valid, n_held_valid;
    t_count                   r_held_start, n_held_start;
    t_count                   r_held_end, n_held_end;
    t_tag                     r_held_tag, n_held_tag;

    t_result                  r_queue [RES_DEPTH];
    logic [RES_PTR_WIDTH-1:0] r_wr_ptr;
    logic [RES_PTR_WIDTH-1:0] r_rd_ptr;
    logic [RES_CNT_WIDTH-1:0] r_count;

    logic                     fold;
    logic                     emit_old;
    logic                     tail_v;
    t_result                  old_res;
    t_result                  tail_res;
    logic [1:0]               push_n;
    logic                     pop;

    // Take an interval only while the queue has room for two beats
    assign o_mv_take = i_mv_valid && (r_count <= RES_CNT_WIDTH'(RES_DEPTH - 2));
    assign pop       = (r_count != '0) && !i_out_stall;

    // Merge decision and the beats it causes
    always_comb begin
        fold = i_cfg.merge_en && r_held_valid && !i_mv.pass
               && (r_held_end >= i_mv.start_cnt);

        old_res.start_cnt = r_held_start;
        old_res.end_cnt   = r_held_end;
        old_res.tag       = r_held_tag;
        old_res.last      = 1'b0;

        n_held_valid = r_held_valid;
        n_held_start = r_held_start;
        n_held_end   = r_held_end;
        n_held_tag   = r_held_tag;

        if (i_mv.pass) begin
            // flush what is held, then send the interval as it came
            emit_old           = r_held_valid;
            tail_v             = 1'b1;
            tail_res.start_cnt = i_mv.start_cnt;
            tail_res.end_cnt   = i_mv.end_cnt;
            tail_res.tag       = i_mv.tag;
            tail_res.last      = i_mv.fin;
            n_held_valid       = 1'b0;
        end else begin
            emit_old     = r_held_valid && !fold;
            n_held_start = fold ? r_held_start : i_mv.start_cnt;
            n_held_end   = i_mv.end_cnt;
            n_held_tag   = fold ? r_held_tag : i_mv.tag;
            n_held_valid = !i_mv.fin;
            // the final interval flushes the updated held one
            tail_v             = i_mv.fin;
            tail_res.start_cnt = n_held_start;
            tail_res.end_cnt   = n_held_end;
            tail_res.tag       = n_held_tag;
            tail_res.last      = 1'b1;
        end

        push_n = o_mv_take ? ({1'b0, emit_old} + {1'b0, tail_v}) : 2'd0;
    end

    // Held interval
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else if (o_mv_take) begin
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mv_take) begin
            r_held_start <= n_held_start;
            r_held_end   <= n_held_end;
            r_held_tag   <= n_held_tag;
        end
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RES_PTR_WIDTH'(push_n);
            r_rd_ptr <= r_rd_ptr + RES_PTR_WIDTH'(pop);
            r_count  <= r_count + RES_CNT_WIDTH'(push_n) - RES_CNT_WIDTH'(pop);
        end
    end

    // Write up to two beats in order
    always_ff @(posedge i_clk) begin
        if (o_mv_take && emit_old) begin
            r_queue[r_wr_ptr] <= old_res;
        end
        if (o_mv_take && tail_v) begin
            r_queue[r_wr_ptr + RES_PTR_WIDTH'(emit_old)] <= tail_res;
        end
    end

    assign o_out_valid = (r_count != '0);
    assign o_res       = r_queue[r_rd_ptr];

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RES_CNT_WIDTH'(RES_DEPTH))
        else $error("result queue overflow");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mv_take && i_mv.fin) |=> !r_held_valid)
        else $error("interval still held after the final one");

    a_pass_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mv_take && i_mv.pass) |=> !r_held_valid)
        else $error("interval held in pass-through mode");

endmodule

FILE: sv/interval_margin_shift_merge_unit.sv
// Interval margin, shift and merge unit.
// Input channel (i_in_valid / o_in_stall) carries one sorted interval per beat:
// start and end counts, a tag and a final marker. Output channel
// (o_out_valid / i_out_stall) carries the moved, saturated intervals; with
// merging enabled and a nonzero margin or shift, overlapping intervals leave
// as one beat with the tag of the first. The final input flushes, and its last
// result has o_out_last set. Each input beat yields zero, one or two result
// beats. A beat passes the input register, the move/saturate register and the
// result queue. Throughput: one interval per clock; the input stalls when the
// four-entry result queue cannot take two more beats, so two-result intervals
// can briefly slow intake to the output rate of one beat per clock. Reset
// (synchronous, active low) clears the held interval and the queue and
// restores the settings: zero margins and shift, merging off, maximum count
// all ones. Settings are written through i_cfg_we / i_cfg_index / i_cfg_data,
// by the user only while no interval is in flight; the block does not enforce
// this. A stalled receiver holds the output beat steady; the queue then fills
// and the input channel stalls in turn.
module interval_margin_shift_merge_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [imsm_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [imsm_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [imsm_pkg::COUNT_WIDTH-1:0]     i_start_count,
    input  logic [imsm_pkg::COUNT_WIDTH-1:0]     i_end_count,
    input  logic [imsm_pkg::TAG_WIDTH-1:0]       i_tag,
    input  logic                                 i_is_final,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [imsm_pkg::COUNT_WIDTH-1:0]     o_out_start,
    output logic [imsm_pkg::COUNT_WIDTH-1:0]     o_out_end,
    output logic [imsm_pkg::TAG_WIDTH-1:0]       o_out_tag,
    output logic                                 o_out_last
);
    import imsm_pkg::*;

    t_cfg    cfg;
    logic    mv_valid;
    logic    mv_take;
    t_move   mv;
    t_result res;

    // Settings
    imsm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input register and move/saturate stage
    imsm_shift u_shift (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_start_count (i_start_count),
        .i_end_count   (i_end_count),
        .i_tag         (i_tag),
        .i_is_final    (i_is_final),
        .o_in_stall    (o_in_stall),
        .i_cfg         (cfg),
        .i_mv_take     (mv_take),
        .o_mv_valid    (mv_valid),
        .o_mv          (mv)
    );

    // Merge stage and result queue
    imsm_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_mv_valid  (mv_valid),
        .i_mv        (mv),
        .o_mv_take   (mv_take),
        .o_out_valid (o_out_valid),
        .o_res       (res),
        .i_out_stall (i_out_stall)
    );

    assign o_out_start = res.start_cnt;
    assign o_out_end   = res.end_cnt;
    assign o_out_tag   = res.tag;
    assign o_out_last  = res.last;

endmodule
